// File: hw/rtl/sample_decimal_ascii_formatter_unit_defines.svh
// Assertion macros for the decimal ASCII formatter.
`ifndef SAMPLE_DECIMAL_ASCII_FORMATTER_UNIT_DEFINES_SVH
`define SAMPLE_DECIMAL_ASCII_FORMATTER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define SDAF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sdaf assertion failed");
// next-cycle implication
`define SDAF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sdaf assertion failed");
`else
`define SDAF_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SDAF_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: hw/rtl/sdaf_pkg.sv
// Shared types and constants for the decimal ASCII formatter.
package sdaf_pkg;

  localparam int SAMPLE_W = 10;
  localparam int CHAR_W   = 8;

  // floor(v / 10) == (v * 205) >> 11 for every v below 1024
  localparam int DIV10_MUL   = 205;
  localparam int DIV10_SHIFT = 11;
  localparam int DIV10_MUL_W = 8;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] ASCII_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] ASCII_COMMA = 8'h2C;
  localparam logic [CHAR_W-1:0] ASCII_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] ASCII_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] ASCII_CR    = 8'h0D;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_DIGIT,
    ST_SEP1,
    ST_SEP2
  } state_t;

  typedef enum logic [1:0] {
    OSEL_DIGIT,
    OSEL_SEP1,
    OSEL_SEP2
  } osel_t;

  typedef struct packed {
    logic  load_val;
    logic  conv_step;
    logic  pop_digit;
    logic  out_load;
    osel_t out_sel;
  } cmd_t;

  typedef struct packed {
    logic quot_zero;
    logic cnt_one;
  } status_t;

endpackage

// File: hw/rtl/sdaf_if.sv
// Request channel interfaces: sample input and ASCII byte output.
interface sdaf_in_if;
  import sdaf_pkg::*;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;
  logic                row_end;
  modport source (output valid, output sample, output row_end, input ready);
  modport sink   (input valid, input sample, input row_end, output ready);
endinterface

interface sdaf_out_if;
  import sdaf_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_out;
  logic              last;
  modport source (output valid, output char_out, output last, input ready);
  modport sink   (input valid, input char_out, input last, output ready);
endinterface

// File: hw/rtl/sdaf_ctrl.sv
// Controller: sequences conversion and byte emission for one request.
module sdaf_ctrl
  import sdaf_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  logic    out_ready,
  output logic    out_valid,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.out_sel   = OSEL_DIGIT;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_val = 1'b1;
          state_nxt    = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.conv_step = 1'b1;
        if (status.quot_zero) state_nxt = ST_DIGIT;
      end
      ST_DIGIT: begin
        if (slot_free) begin
          cmd.out_load  = 1'b1;
          cmd.pop_digit = 1'b1;
          if (status.cnt_one) state_nxt = ST_SEP1;
        end
      end
      ST_SEP1: begin
        cmd.out_sel = OSEL_SEP1;
        if (slot_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_SEP2;
        end
      end
      ST_SEP2: begin
        cmd.out_sel = OSEL_SEP2;
        if (slot_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    out_valid_nxt = cmd.out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

endmodule

// File: hw/rtl/sdaf_dpath.sv
// Datapath: divide-by-ten digit extraction, digit stack and output byte register.
module sdaf_dpath
  import sdaf_pkg::*;
#(
  parameter int VAL_W = 10,
  parameter int NDIG  = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [SAMPLE_W-1:0] sample,
  input  logic                row_end,
  input  cmd_t                cmd,
  output status_t             status,
  output logic [CHAR_W-1:0]   char_out,
  output logic                last
);

  localparam int CNT_W  = $clog2(NDIG + 1);
  localparam int PROD_W = VAL_W + DIV10_MUL_W;

  logic [VAL_W-1:0]  val_r;
  logic              row_end_r;
  logic [3:0]        stack_r [NDIG];
  logic [CNT_W-1:0]  cnt_r;
  logic [CHAR_W-1:0] char_r;
  logic              last_r;

  logic [PROD_W-1:0] prod;
  logic [VAL_W-1:0]  quot;
  logic [VAL_W-1:0]  quot_x10;
  logic [3:0]        rem;
  logic [CHAR_W-1:0] char_nxt;
  logic              last_nxt;

  assign prod     = PROD_W'(val_r) * PROD_W'(DIV10_MUL);
  assign quot     = VAL_W'(prod[PROD_W-1:DIV10_SHIFT]);
  // only the low bits of quot*10 matter, the remainder is below ten
  assign quot_x10 = {quot[VAL_W-4:0], 3'b000} + {quot[VAL_W-2:0], 1'b0};
  assign rem      = 4'(val_r - quot_x10);

  assign status.quot_zero = (quot == '0);
  assign status.cnt_one   = (cnt_r == CNT_W'(1));

  always_comb begin
    char_nxt = ASCII_ZERO + CHAR_W'(stack_r[0]);
    last_nxt = 1'b0;
    case (cmd.out_sel)
      OSEL_DIGIT: char_nxt = ASCII_ZERO + CHAR_W'(stack_r[0]);
      OSEL_SEP1:  char_nxt = row_end_r ? ASCII_LF : ASCII_COMMA;
      OSEL_SEP2: begin
        char_nxt = row_end_r ? ASCII_CR : ASCII_SPACE;
        last_nxt = 1'b1;
      end
      default: char_nxt = ASCII_ZERO;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.load_val) begin
      cnt_r <= '0;
    end else if (cmd.conv_step) begin
      cnt_r <= cnt_r + CNT_W'(1);
    end else if (cmd.pop_digit) begin
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  // LIFO: conversion pushes least significant digit first, emission pops from the top
  always_ff @(posedge clk) begin
    if (cmd.load_val) begin
      val_r     <= sample[VAL_W-1:0];
      row_end_r <= row_end;
    end
    if (cmd.conv_step) begin
      val_r      <= quot;
      stack_r[0] <= rem;
      for (int i = 1; i < NDIG; i++) stack_r[i] <= stack_r[i-1];
    end else if (cmd.pop_digit) begin
      for (int i = 0; i < NDIG - 1; i++) stack_r[i] <= stack_r[i+1];
    end
    if (cmd.out_load) begin
      char_r <= char_nxt;
      last_r <= last_nxt;
    end
  end

  assign char_out = char_r;
  assign last     = last_r;

endmodule

// File: hw/rtl/sample_decimal_ascii_formatter_unit.sv
// Top level of the sample decimal ASCII formatter.
// Each accepted request (a sample and a row_end flag) is printed as its decimal
// digits in ASCII, most significant first without leading zeros ('0' for zero),
// followed by ", " or LF CR; last marks the final separator byte. Only the low
// SAMPLE_BITS bits (at most SAMPLE_W) of the sample are used. One request is handled
// at a time: it is taken in ST_IDLE, converted one digit per cycle through the
// divide-by-ten unit, then emitted one output byte per cycle while the output side
// does not stall. The next request is taken while the final byte still waits in
// the output register.
`include "sample_decimal_ascii_formatter_unit_defines.svh"

module sample_decimal_ascii_formatter_unit
  import sdaf_pkg::*;
#(
  parameter int SAMPLE_BITS = 10
) (
  input  logic       clk,
  input  logic       rst_n,
  sdaf_in_if.sink    in_ch,
  sdaf_out_if.source out_ch
);

  localparam int VAL_W = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
  localparam int NDIG  = (VAL_W >= 10) ? 4 : ((VAL_W >= 7) ? 3 : 2);

  cmd_t    cmd;
  status_t status;

  sdaf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .status    (status),
    .cmd       (cmd)
  );

  sdaf_dpath #(
    .VAL_W (VAL_W),
    .NDIG  (NDIG)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .sample   (in_ch.sample),
    .row_end  (in_ch.row_end),
    .cmd      (cmd),
    .status   (status),
    .char_out (out_ch.char_out),
    .last     (out_ch.last)
  );

  // a new request is never taken straight after one
  `SDAF_ASSERT_NXT(a_one_at_a_time, clk, rst_n, in_ch.valid && in_ch.ready, !in_ch.ready)
  // final byte is always the second separator
  `SDAF_ASSERT_IMP(a_last_is_sep2, clk, rst_n, out_ch.valid && out_ch.last, (out_ch.char_out == ASCII_SPACE) || (out_ch.char_out == ASCII_CR))
  // other bytes are digits or the first separator
  `SDAF_ASSERT_IMP(a_body_bytes, clk, rst_n, out_ch.valid && !out_ch.last, ((out_ch.char_out >= ASCII_ZERO) && (out_ch.char_out <= ASCII_NINE)) || (out_ch.char_out == ASCII_COMMA) || (out_ch.char_out == ASCII_LF))

endmodule
